>>> rtl/tmox_pkg.sv
// Shared widths, op codes and status codes for the tape machine op executor.
package tmox_pkg;

    localparam int TAPE_DEPTH_DEF = 4096;
    localparam int IP_WIDTH_DEF   = 16;

    localparam int CMD_W  = 3;
    localparam int OPND_W = 16;
    localparam int BYTE_W = 8;
    localparam int ST_W   = 3;
    localparam int PLEN_W = 16;
    localparam int NIP_W  = 16;
    localparam int REP_W  = 16;

    typedef logic [CMD_W-1:0] cmd_t;
    typedef logic [ST_W-1:0]  status_t;

    localparam cmd_t CMD_INC   = 3'd0;
    localparam cmd_t CMD_DEC   = 3'd1;
    localparam cmd_t CMD_LEFT  = 3'd2;
    localparam cmd_t CMD_RIGHT = 3'd3;
    localparam cmd_t CMD_JZ    = 3'd4;
    localparam cmd_t CMD_JNZ   = 3'd5;
    localparam cmd_t CMD_IN    = 3'd6;
    localparam cmd_t CMD_OUT   = 3'd7;

    localparam status_t ST_RUNNING   = 3'd0;
    localparam status_t ST_EOF_HALT  = 3'd1;
    localparam status_t ST_LEFT_ERR  = 3'd2;
    localparam status_t ST_RIGHT_ERR = 3'd3;
    localparam status_t ST_DONE      = 3'd4;

endpackage

>>> rtl/tmox_ifs.sv
// Channel interfaces of the tape machine op executor: ops in, results out, configuration.
interface tmox_op_if
    import tmox_pkg::*;
();
    logic              valid;
    logic              ready;
    cmd_t              command;
    logic [OPND_W-1:0] operand;
    logic [BYTE_W-1:0] in_byte;
    logic              in_eof;

    modport source (output valid, command, operand, in_byte, in_eof, input ready);
    modport sink   (input valid, command, operand, in_byte, in_eof, output ready);
endinterface

interface tmox_res_if
    import tmox_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [NIP_W-1:0]  next_ip;
    logic              jumped;
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic [REP_W-1:0]  out_repeat;
    status_t           status;

    modport source (output valid, next_ip, jumped, out_valid, out_byte, out_repeat, status,
                    input ready);
    modport sink   (input valid, next_ip, jumped, out_valid, out_byte, out_repeat, status,
                    output ready);
endinterface

interface tmox_cfg_if
    import tmox_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PLEN_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/tape_machine_op_executor_core.sv
// Top level of the tape machine op executor: op register, execute logic and result register.
//
// The block executes one run-length tape-machine op per clock cycle unless the result
// channel stalls: an accepted op is held in the op register, executed once the result
// register is free, and its result beat is offered from the result register, so ops may
// follow back to back. The byte tape lives in a TAPE_DEPTH-entry memory; the current cell
// is held in a register and written through to the memory, and a pointer move reads the
// new cell in the same cycle so that it is ready for the very next op. After reset it
// clears all TAPE_DEPTH cells (4096 by default), one cell per cycle, accepting no op then;
// the program length register may be written at any idle time, including during the clear.
module tape_machine_op_executor_core
    import tmox_pkg::*;
#(
    parameter int TAPE_DEPTH = TAPE_DEPTH_DEF,
    parameter int IP_WIDTH   = IP_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    tmox_op_if.sink       ops,
    tmox_res_if.source    results,
    tmox_cfg_if.sink      cfg
);

    localparam int DP_W  = $clog2(TAPE_DEPTH);
    localparam int SUM_W = ((DP_W > OPND_W) ? DP_W : OPND_W) + 1;
    localparam int CMP_W = (IP_WIDTH > PLEN_W) ? IP_WIDTH : PLEN_W;
    localparam logic [DP_W-1:0] LAST_ADDR = DP_W'(TAPE_DEPTH - 1);

    logic [BYTE_W-1:0] tape_mem [TAPE_DEPTH];

    logic [PLEN_W-1:0]   plen_reg;
    logic                clearing_reg;
    logic [DP_W-1:0]     clr_addr_reg;

    logic                s1_valid_reg;
    cmd_t                s1_cmd_reg;
    logic [OPND_W-1:0]   s1_opnd_reg;
    logic [BYTE_W-1:0]   s1_byte_reg;
    logic                s1_eof_reg;

    logic [DP_W-1:0]     dp_reg;
    logic [IP_WIDTH-1:0] ip_reg;
    logic                halted_reg;
    status_t             halt_code_reg;
    logic [BYTE_W-1:0]   cell_reg;
    logic                pending_reg;
    logic [BYTE_W-1:0]   mem_q_reg;

    logic                res_valid_reg;
    logic [NIP_W-1:0]    res_nip_reg;
    logic                res_jumped_reg;
    logic                res_ovalid_reg;
    logic [BYTE_W-1:0]   res_obyte_reg;
    logic [REP_W-1:0]    res_orep_reg;
    status_t             res_status_reg;

    logic                res_free;
    logic                exec;
    logic                op_take;
    logic [BYTE_W-1:0]   cur_cell;
    logic [IP_WIDTH-1:0] ip_plus1;
    logic [IP_WIDTH-1:0] jump_tgt;
    logic                ip_done;
    logic [SUM_W-1:0]    dp_ext;
    logic [SUM_W-1:0]    opnd_ext;
    logic [SUM_W-1:0]    right_sum;
    logic                left_bad;
    logic                right_bad;

    logic [IP_WIDTH-1:0] nip;
    logic                jumped;
    logic                ovalid;
    logic [BYTE_W-1:0]   obyte;
    logic [REP_W-1:0]    orep;
    status_t             status;
    logic [BYTE_W-1:0]   new_cell;
    logic                cell_wr;
    logic [DP_W-1:0]     new_dp;
    logic                moved;
    logic                stop;
    logic                wr_en;
    logic                rd_en;

    // Handshakes
    assign res_free    = !res_valid_reg || results.ready;
    assign exec        = s1_valid_reg && res_free;
    assign ops.ready   = !clearing_reg && (!s1_valid_reg || exec);
    assign op_take     = ops.valid && ops.ready;
    assign cfg.ready   = 1'b1;

    assign results.valid      = res_valid_reg;
    assign results.next_ip    = res_nip_reg;
    assign results.jumped     = res_jumped_reg;
    assign results.out_valid  = res_ovalid_reg;
    assign results.out_byte   = res_obyte_reg;
    assign results.out_repeat = res_orep_reg;
    assign results.status     = res_status_reg;

    // After a pointer move the new cell arrives from the memory read register.
    assign cur_cell  = pending_reg ? mem_q_reg : cell_reg;
    assign ip_plus1  = ip_reg + IP_WIDTH'(1);
    assign jump_tgt  = IP_WIDTH'(s1_opnd_reg);
    assign ip_done   = CMP_W'(ip_reg) >= CMP_W'(plen_reg);
    assign dp_ext    = SUM_W'(dp_reg);
    assign opnd_ext  = SUM_W'(s1_opnd_reg);
    assign right_sum = dp_ext + opnd_ext;
    assign left_bad  = dp_ext < opnd_ext;
    assign right_bad = right_sum >= SUM_W'(TAPE_DEPTH);

    always_comb
    begin
        nip      = ip_plus1;
        jumped   = 1'b0;
        ovalid   = 1'b0;
        obyte    = '0;
        orep     = '0;
        status   = ST_RUNNING;
        new_cell = cur_cell;
        cell_wr  = 1'b0;
        new_dp   = dp_reg;
        moved    = 1'b0;
        stop     = 1'b0;
        if (halted_reg)
        begin
            nip    = ip_reg;
            status = halt_code_reg;
        end
        else if (ip_done)
        begin
            nip    = ip_reg;
            status = ST_DONE;
            stop   = 1'b1;
        end
        else
        begin
            unique case (s1_cmd_reg)
                CMD_INC:
                begin
                    new_cell = cur_cell + s1_opnd_reg[BYTE_W-1:0];
                    cell_wr  = 1'b1;
                end
                CMD_DEC:
                begin
                    new_cell = cur_cell - s1_opnd_reg[BYTE_W-1:0];
                    cell_wr  = 1'b1;
                end
                CMD_LEFT:
                begin
                    if (left_bad)
                    begin
                        nip    = ip_reg;
                        status = ST_LEFT_ERR;
                        stop   = 1'b1;
                    end
                    else
                    begin
                        new_dp = DP_W'(dp_ext - opnd_ext);
                        moved  = 1'b1;
                    end
                end
                CMD_RIGHT:
                begin
                    if (right_bad)
                    begin
                        nip    = ip_reg;
                        status = ST_RIGHT_ERR;
                        stop   = 1'b1;
                    end
                    else
                    begin
                        new_dp = DP_W'(right_sum);
                        moved  = 1'b1;
                    end
                end
                CMD_JZ:
                begin
                    if (cur_cell == '0)
                    begin
                        nip    = jump_tgt;
                        jumped = 1'b1;
                    end
                end
                CMD_JNZ:
                begin
                    if (cur_cell != '0)
                    begin
                        nip    = jump_tgt;
                        jumped = 1'b1;
                    end
                end
                CMD_IN:
                begin
                    if (s1_eof_reg)
                    begin
                        nip    = ip_reg;
                        status = ST_EOF_HALT;
                        stop   = 1'b1;
                    end
                    else
                    begin
                        new_cell = s1_byte_reg;
                        cell_wr  = 1'b1;
                    end
                end
                CMD_OUT:
                begin
                    if (s1_opnd_reg != '0)
                    begin
                        ovalid = 1'b1;
                        obyte  = cur_cell;
                        orep   = REP_W'(s1_opnd_reg);
                    end
                end
            endcase
            // An op that leaves the pointer at or past the end finishes the program.
            if (!stop && (CMP_W'(nip) >= CMP_W'(plen_reg)))
            begin
                status = ST_DONE;
                stop   = 1'b1;
            end
        end
    end

    assign wr_en = exec && cell_wr;
    assign rd_en = exec && moved;

    // Tape memory: clearing sweep or write-through of the current cell, one read port.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            tape_mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            tape_mem[dp_reg] <= new_cell;
        end
        if (rd_en)
        begin
            mem_q_reg <= tape_mem[new_dp];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            dp_reg        <= '0;
            ip_reg        <= '0;
            halted_reg    <= 1'b0;
            halt_code_reg <= ST_RUNNING;
            cell_reg      <= '0;
            pending_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                plen_reg <= cfg.data;
            end
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + DP_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (op_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (exec)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (exec)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (exec && !halted_reg)
            begin
                ip_reg      <= nip;
                dp_reg      <= new_dp;
                cell_reg    <= new_cell;
                pending_reg <= moved;
                if (stop)
                begin
                    halted_reg    <= 1'b1;
                    halt_code_reg <= status;
                end
            end
        end
    end

    // Op and result payload registers
    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            s1_cmd_reg  <= ops.command;
            s1_opnd_reg <= ops.operand;
            s1_byte_reg <= ops.in_byte;
            s1_eof_reg  <= ops.in_eof;
        end
        if (exec)
        begin
            res_nip_reg    <= NIP_W'(nip);
            res_jumped_reg <= jumped;
            res_ovalid_reg <= ovalid;
            res_obyte_reg  <= obyte;
            res_orep_reg   <= orep;
            res_status_reg <= status;
        end
    end

endmodule
